@@ design/mhpf_pkg.sv @@
// ----------------------------------------------------------------------------
// mhpf_pkg
// shared types and constants of the multichannel high-pass filter
// ----------------------------------------------------------------------------
package mhpf_pkg;

  localparam int CHAN_W   = 3;   // channel field of an item
  localparam int FACTOR_W = 16;  // filter coefficient, unsigned q0.16
  localparam int GAIN_W   = 16;  // output gain, unsigned q8.8
  localparam int NCH_W    = 4;   // channel count register
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_FACTOR = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_NCH    = 2'd2;

  localparam logic [FACTOR_W-1:0] FACTOR_RESET = 16'd62259;
  localparam logic [GAIN_W-1:0]   GAIN_RESET   = 16'd256;
  localparam logic [NCH_W-1:0]    NCH_RESET    = 4'd1;

  localparam int FACTOR_SHIFT = 16;
  localparam int GAIN_SHIFT   = 8;

  localparam logic ACT_FILTER = 1'b0;
  localparam logic ACT_CLEAR  = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_MUL1 = 4'b0010,
    ST_MUL2 = 4'b0100,
    ST_FIN  = 4'b1000
  } state_t;

  typedef struct packed {
    logic rd_en;
    logic wr_en;
    logic clr;
  } hist_ctrl_t;

endpackage

@@ design/mhpf_in_if.sv @@
// ----------------------------------------------------------------------------
// mhpf_in_if
// input channel: action, channel and sample with valid/ready
// ----------------------------------------------------------------------------
interface mhpf_in_if #(
  parameter int SAMPLE_WIDTH = 16
) ();
  logic                            valid;
  logic                            ready;
  logic                            action;
  logic [mhpf_pkg::CHAN_W-1:0]     channel;
  logic signed [SAMPLE_WIDTH-1:0]  sample;

  modport source (output valid, action, channel, sample, input ready);
  modport sink   (input valid, action, channel, sample, output ready);
endinterface

@@ design/mhpf_out_if.sv @@
// ----------------------------------------------------------------------------
// mhpf_out_if
// result channel: channel, filtered sample and error flag with valid/ready
// ----------------------------------------------------------------------------
interface mhpf_out_if #(
  parameter int SAMPLE_WIDTH = 16
) ();
  logic                            valid;
  logic                            ready;
  logic [mhpf_pkg::CHAN_W-1:0]     out_channel;
  logic signed [SAMPLE_WIDTH-1:0]  filtered;
  logic                            channel_error;

  modport source (output valid, out_channel, filtered, channel_error, input ready);
  modport sink   (input valid, out_channel, filtered, channel_error, output ready);
endinterface

@@ design/mhpf_mul.sv @@
// ----------------------------------------------------------------------------
// mhpf_mul
// shared signed multiplier with registered product
// ----------------------------------------------------------------------------
module mhpf_mul #(
  parameter int A_W = 19,
  parameter int B_W = 17
) (
  input  logic                   clk,
  input  logic                   en,
  input  logic signed [A_W-1:0]  a,
  input  logic signed [B_W-1:0]  b,
  output logic signed [A_W+B_W-1:0] p
);

  always_ff @(posedge clk) begin
    if (en) begin
      p <= a * b;
    end
  end

endmodule

@@ design/mhpf_hist.sv @@
// ----------------------------------------------------------------------------
// mhpf_hist
// per-channel history memory (last input, last output) with valid bits
// ----------------------------------------------------------------------------
module mhpf_hist #(
  parameter int DEPTH  = 8,
  parameter int IDX_W  = 3,
  parameter int DATA_W = 16
) (
  input  logic                     clk,
  input  logic                     rst,
  input  mhpf_pkg::hist_ctrl_t     ctrl,
  input  logic [IDX_W-1:0]         rd_idx,
  input  logic [IDX_W-1:0]         wr_idx,
  input  logic signed [DATA_W-1:0] wr_x,
  input  logic signed [DATA_W-1:0] wr_y,
  output logic signed [DATA_W-1:0] rd_x,
  output logic signed [DATA_W-1:0] rd_y
);

  logic [2*DATA_W-1:0] mem [DEPTH];
  logic [DEPTH-1:0]    vld;
  logic [2*DATA_W-1:0] rd_data;
  logic                rd_vld;

  always_ff @(posedge clk) begin
    if (ctrl.wr_en) begin
      mem[wr_idx] <= {wr_y, wr_x};
    end
    if (ctrl.rd_en) begin
      rd_data <= mem[rd_idx];
    end
  end

  // entries not written since reset or clear read as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      vld    <= '0;
      rd_vld <= 1'b0;
    end else begin
      if (ctrl.clr) begin
        vld <= '0;
      end else if (ctrl.wr_en) begin
        vld[wr_idx] <= 1'b1;
      end
      if (ctrl.rd_en) begin
        rd_vld <= vld[rd_idx];
      end
    end
  end

  assign rd_x = rd_vld ? $signed(rd_data[DATA_W-1:0])        : '0;
  assign rd_y = rd_vld ? $signed(rd_data[2*DATA_W-1:DATA_W]) : '0;

endmodule

@@ design/multichannel_high_pass_filter.sv @@
// ----------------------------------------------------------------------------
// multichannel_high_pass_filter
// per-channel first-order high-pass filter with output gain
//
// order: a sample item passes mul1, mul2 and fin into the output register;
//   a clear or bad-channel item goes from accept straight to fin
// flow: a new item is accepted only in idle, after the previous one is parked;
//   a sample item uses the single multiplier twice in sequence
// reset: synchronous; configuration registers return to defaults, history reads as zero
// ----------------------------------------------------------------------------
module multichannel_high_pass_filter #(
  parameter int MAX_CHANNELS = 8,
  parameter int SAMPLE_WIDTH = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [mhpf_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [mhpf_pkg::CFG_DATA_W-1:0]     cfg_data,
  mhpf_in_if.sink                             samples,
  mhpf_out_if.source                          results
);

  localparam int IDX_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int SW    = SAMPLE_WIDTH;
  localparam int DW    = SW + 2;                  // y_prev + x - x_prev
  localparam int AW    = SW + 3;                  // multiplier a operand
  localparam int BW    = mhpf_pkg::FACTOR_W + 1;  // unsigned coefficient, signed form
  localparam int PW    = AW + BW;
  localparam int QW    = PW - mhpf_pkg::GAIN_SHIFT;

  localparam logic signed [SW-1:0] Y_MAX = {1'b0, {(SW-1){1'b1}}};
  localparam logic signed [SW-1:0] Y_MIN = {1'b1, {(SW-1){1'b0}}};

  // configuration registers
  logic [mhpf_pkg::FACTOR_W-1:0] filter_factor;
  logic [mhpf_pkg::GAIN_W-1:0]   output_gain;
  logic [mhpf_pkg::NCH_W-1:0]    num_channels;

  // sequencer and item registers
  mhpf_pkg::state_t              state, state_next;
  logic                          item_action;
  logic                          item_err;
  logic [mhpf_pkg::CHAN_W-1:0]   item_channel;
  logic signed [SW-1:0]          item_sample;

  // output register
  logic                          out_valid;
  logic [mhpf_pkg::CHAN_W-1:0]   out_channel;
  logic signed [SW-1:0]          filtered;
  logic                          channel_error;

  logic                          accept;
  logic                          load;
  logic                          in_err;
  mhpf_pkg::hist_ctrl_t          hist_ctrl;
  logic signed [SW-1:0]          x_prev, y_prev;
  logic signed [DW-1:0]          d;
  logic signed [AW-1:0]          mul_a;
  logic signed [BW-1:0]          mul_b;
  logic signed [PW-1:0]          prod;
  logic signed [AW-1:0]          p;
  logic signed [QW-1:0]          q;
  logic signed [SW-1:0]          y;

  // ---------------------------------------------------------------- config
  // writes of zero are dropped, unknown indexes ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      filter_factor <= mhpf_pkg::FACTOR_RESET;
      output_gain   <= mhpf_pkg::GAIN_RESET;
      num_channels  <= mhpf_pkg::NCH_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        mhpf_pkg::REG_FACTOR: begin
          if (cfg_data[mhpf_pkg::FACTOR_W-1:0] != '0) begin
            filter_factor <= cfg_data[mhpf_pkg::FACTOR_W-1:0];
          end
        end
        mhpf_pkg::REG_GAIN: begin
          if (cfg_data[mhpf_pkg::GAIN_W-1:0] != '0) begin
            output_gain <= cfg_data[mhpf_pkg::GAIN_W-1:0];
          end
        end
        mhpf_pkg::REG_NCH: begin
          if (cfg_data[mhpf_pkg::NCH_W-1:0] != '0) begin
            num_channels <= cfg_data[mhpf_pkg::NCH_W-1:0];
          end
        end
        default: begin
        end
      endcase
    end
  end

  // ---------------------------------------------------------------- input side
  assign samples.ready = (state == mhpf_pkg::ST_IDLE);
  assign accept        = samples.valid && samples.ready;

  // channel beyond the configured count or beyond the storage is rejected
  assign in_err = ({1'b0, samples.channel} >= num_channels) ||
                  (32'(samples.channel) >= 32'(MAX_CHANNELS));

  always_ff @(posedge clk) begin
    if (accept) begin
      item_action  <= samples.action;
      item_err     <= in_err;
      item_channel <= samples.channel;
      item_sample  <= samples.sample;
    end
  end

  // ---------------------------------------------------------------- sequencer
  // idle -> mul1 (d * factor) -> mul2 (p * gain) -> fin (saturate, write back)
  // clear and rejected items go straight to fin
  always_comb begin
    state_next = state;
    case (state)
      mhpf_pkg::ST_IDLE: begin
        if (accept) begin
          if (samples.action == mhpf_pkg::ACT_CLEAR || in_err) begin
            state_next = mhpf_pkg::ST_FIN;
          end else begin
            state_next = mhpf_pkg::ST_MUL1;
          end
        end
      end
      mhpf_pkg::ST_MUL1: state_next = mhpf_pkg::ST_MUL2;
      mhpf_pkg::ST_MUL2: state_next = mhpf_pkg::ST_FIN;
      mhpf_pkg::ST_FIN: begin
        if (load) begin
          state_next = mhpf_pkg::ST_IDLE;
        end
      end
      default: state_next = mhpf_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mhpf_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // ---------------------------------------------------------------- history
  // read at accept so the previous x and y are ready in mul1
  assign hist_ctrl.rd_en = accept;
  assign hist_ctrl.wr_en = load && (item_action == mhpf_pkg::ACT_FILTER) && !item_err;
  assign hist_ctrl.clr   = load && (item_action == mhpf_pkg::ACT_CLEAR);

  mhpf_hist #(
    .DEPTH  (MAX_CHANNELS),
    .IDX_W  (IDX_W),
    .DATA_W (SW)
  ) u_hist (
    .clk    (clk),
    .rst    (rst),
    .ctrl   (hist_ctrl),
    .rd_idx (IDX_W'(samples.channel)),
    .wr_idx (IDX_W'(item_channel)),
    .wr_x   (item_sample),
    .wr_y   (y),
    .rd_x   (x_prev),
    .rd_y   (y_prev)
  );

  // ---------------------------------------------------------------- datapath
  // exact difference term, then the two products on one multiplier
  assign d = {{2{y_prev[SW-1]}}, y_prev} + {{2{item_sample[SW-1]}}, item_sample}
           - {{2{x_prev[SW-1]}}, x_prev};

  // p = floor(d * factor / 2^16); product is still held from mul1 during mul2
  assign p = prod[mhpf_pkg::FACTOR_SHIFT +: AW];

  always_comb begin
    if (state == mhpf_pkg::ST_MUL1) begin
      mul_a = {d[DW-1], d};
      mul_b = $signed({1'b0, filter_factor});
    end else begin
      mul_a = p;
      mul_b = $signed({1'b0, output_gain});
    end
  end

  mhpf_mul #(
    .A_W (AW),
    .B_W (BW)
  ) u_mul (
    .clk (clk),
    .en  ((state == mhpf_pkg::ST_MUL1) || (state == mhpf_pkg::ST_MUL2)),
    .a   (mul_a),
    .b   (mul_b),
    .p   (prod)
  );

  // q = floor(p * gain / 2^8), then saturate to the sample range
  assign q = prod[PW-1:mhpf_pkg::GAIN_SHIFT];

  always_comb begin
    if (q > QW'(Y_MAX)) begin
      y = Y_MAX;
    end else if (q < QW'(Y_MIN)) begin
      y = Y_MIN;
    end else begin
      y = q[SW-1:0];
    end
  end

  // ---------------------------------------------------------------- output side
  // output register frees the sequencer as soon as the result is parked
  assign load = (state == mhpf_pkg::ST_FIN) && (!out_valid || results.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_channel   <= item_channel;
      channel_error <= item_err && (item_action == mhpf_pkg::ACT_FILTER);
      if (item_action == mhpf_pkg::ACT_FILTER && !item_err) begin
        filtered <= y;
      end else begin
        filtered <= '0;
      end
    end
  end

  assign results.valid         = out_valid;
  assign results.out_channel   = out_channel;
  assign results.filtered      = filtered;
  assign results.channel_error = channel_error;

  // ---------------------------------------------------------------- checks
  // an accepted item always moves the sequencer out of idle
  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == mhpf_pkg::ST_MUL1) || (state == mhpf_pkg::ST_FIN))
    else $error("accepted item did not start the sequencer");

  // the two products follow each other without a gap
  a_mul_order: assert property (@(posedge clk) disable iff (rst)
    (state == mhpf_pkg::ST_MUL1) |=> (state == mhpf_pkg::ST_MUL2))
    else $error("second product not taken right after the first");

  // history is never written for a clear or a rejected channel
  a_no_bad_write: assert property (@(posedge clk) disable iff (rst)
    hist_ctrl.wr_en |-> !item_err && (item_action == mhpf_pkg::ACT_FILTER))
    else $error("history written for a clear or rejected item");

  // a rejected channel reports a zero sample
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (results.valid && results.channel_error) |-> (results.filtered == '0))
    else $error("rejected channel carries a nonzero sample");

endmodule
